FILE: rtl/eatq_pkg.sv
// Shared constants, widths and the arctangent table for the Euler angle to
// quaternion converter. No dependencies.
package eatq_pkg;

   localparam int ANGLE_BITS_DEF     = 16;
   localparam int QUAT_FRAC_BITS_DEF = 14;
   localparam int CORDIC_STEPS_DEF   = 16;

   localparam int TABLE_LEN   = 32;
   localparam int WORK_FRAC   = 20;
   localparam int VEC_FRAC    = 30;
   localparam int CORDIC_GAIN = 652032874;

   localparam int XY_W   = 33;
   localparam int Z_W    = 36;
   localparam int SC_W   = WORK_FRAC + 2;
   localparam int PROD_W = 2 * SC_W;

   function automatic longint atan_turn32(input int idx);
      longint val;
      case (idx)
         0:       val = 536870912;
         1:       val = 316933406;
         2:       val = 167458907;
         3:       val = 85004756;
         4:       val = 42667331;
         5:       val = 21354465;
         6:       val = 10679838;
         7:       val = 5340245;
         8:       val = 2670163;
         9:       val = 1335086;
         10:      val = 667544;
         11:      val = 333772;
         12:      val = 166886;
         13:      val = 83443;
         14:      val = 41722;
         15:      val = 20861;
         16:      val = 10430;
         17:      val = 5215;
         18:      val = 2608;
         19:      val = 1304;
         20:      val = 652;
         21:      val = 326;
         22:      val = 163;
         23:      val = 81;
         24:      val = 41;
         25:      val = 20;
         26:      val = 10;
         27:      val = 5;
         28:      val = 3;
         29:      val = 1;
         30:      val = 1;
         default: val = 0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/eatq_req_if.sv
// Request channel carrying one triple of binary angles per word.
// Depends on eatq_pkg for the default angle width.
interface eatq_req_if #(
   parameter int ANGLE_BITS = eatq_pkg::ANGLE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] roll_angle;
   logic signed [ANGLE_BITS-1:0] pitch_angle;
   logic signed [ANGLE_BITS-1:0] yaw_angle;

   modport source (output valid, output roll_angle, output pitch_angle, output yaw_angle,
                   input ready);
   modport sink   (input valid, input roll_angle, input pitch_angle, input yaw_angle,
                   output ready);
endinterface

FILE: rtl/eatq_rsp_if.sv
// Response channel carrying one quaternion per word.
// Depends on eatq_pkg for the default component width.
interface eatq_rsp_if #(
   parameter int QUAT_W = eatq_pkg::QUAT_FRAC_BITS_DEF + 2
);
   logic                     valid;
   logic                     ready;
   logic signed [QUAT_W-1:0] quat_x;
   logic signed [QUAT_W-1:0] quat_y;
   logic signed [QUAT_W-1:0] quat_z;
   logic signed [QUAT_W-1:0] quat_w;

   modport source (output valid, output quat_x, output quat_y, output quat_z, output quat_w,
                   input ready);
   modport sink   (input valid, input quat_x, input quat_y, input quat_z, input quat_w,
                   output ready);
endinterface

FILE: rtl/eatq_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of half a binary angle
// in Q20, one step per stage. Depends on eatq_pkg.
module eatq_cordic #(
   parameter int ANGLE_BITS = eatq_pkg::ANGLE_BITS_DEF,
   parameter int STEPS      = eatq_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [ANGLE_BITS-1:0]      angle,
   output logic signed [eatq_pkg::SC_W-1:0]  sin_val,
   output logic signed [eatq_pkg::SC_W-1:0]  cos_val
);
   localparam int XW = eatq_pkg::XY_W;
   localparam int ZW = eatq_pkg::Z_W;
   localparam int SW = eatq_pkg::SC_W;
   localparam int RS = eatq_pkg::VEC_FRAC - eatq_pkg::WORK_FRAC;
   localparam logic signed [XW-1:0] RND_HALF = XW'(1) <<< (RS - 1);
   localparam logic signed [XW-1:0] LIM      = XW'(1) <<< eatq_pkg::WORK_FRAC;

   logic signed [XW-1:0] x_ff [0:STEPS];
   logic signed [XW-1:0] x_in [0:STEPS];
   logic signed [XW-1:0] y_ff [0:STEPS];
   logic signed [XW-1:0] y_in [0:STEPS];
   logic signed [ZW-1:0] z_ff [0:STEPS];
   logic signed [ZW-1:0] z_in [0:STEPS];
   logic signed [XW-1:0] cos_rnd;
   logic signed [XW-1:0] sin_rnd;
   logic signed [SW-1:0] cos_ff;
   logic signed [SW-1:0] cos_in;
   logic signed [SW-1:0] sin_ff;
   logic signed [SW-1:0] sin_in;

   // The half angle lands exactly on the 2^34-per-turn accumulator scale.
   assign x_in[0] = XW'(eatq_pkg::CORDIC_GAIN);
   assign y_in[0] = '0;
   assign z_in[0] = ZW'(angle) <<< (33 - ANGLE_BITS);

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] DA = ZW'(eatq_pkg::atan_turn32(i) * 64'sd4);
      logic neg;
      assign neg       = z_ff[i][ZW-1];
      assign x_in[i+1] = neg ? x_ff[i] + (y_ff[i] >>> i) : x_ff[i] - (y_ff[i] >>> i);
      assign y_in[i+1] = neg ? y_ff[i] - (x_ff[i] >>> i) : y_ff[i] + (x_ff[i] >>> i);
      assign z_in[i+1] = neg ? z_ff[i] + DA : z_ff[i] - DA;
   end

   assign cos_rnd = (x_ff[STEPS] + RND_HALF) >>> RS;
   assign sin_rnd = (y_ff[STEPS] + RND_HALF) >>> RS;
   assign cos_in  = (cos_rnd > LIM) ? SW'(LIM) : (cos_rnd < -LIM) ? SW'(-LIM) : SW'(cos_rnd);
   assign sin_in  = (sin_rnd > LIM) ? SW'(LIM) : (sin_rnd < -LIM) ? SW'(-LIM) : SW'(sin_rnd);

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k <= STEPS; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

FILE: rtl/euler_angles_to_quaternion.sv
// Euler angle (Z-Y-X) to unit quaternion converter, fully pipelined.
// Its stages are one load stage, one stage per CORDIC step,
// one rounding stage, then two multiply stages each followed by a rounding stage.
// Throughput is one word per cycle; a stalled output freezes the whole pipeline.
// Synchronous reset clears only the valid bits. Depends on eatq_pkg, eatq_cordic
// and the channel interfaces.
module euler_angles_to_quaternion #(
   parameter int ANGLE_BITS     = eatq_pkg::ANGLE_BITS_DEF,
   parameter int QUAT_FRAC_BITS = eatq_pkg::QUAT_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS   = eatq_pkg::CORDIC_STEPS_DEF
) (
   input logic     clock,
   input logic     reset,
   eatq_req_if.sink   req_chan,
   eatq_rsp_if.source rsp_chan
);
   localparam int N   = (CORDIC_STEPS > eatq_pkg::TABLE_LEN) ? eatq_pkg::TABLE_LEN
                                                            : CORDIC_STEPS;
   localparam int LAT = N + 6;
   localparam int QW  = QUAT_FRAC_BITS + 2;
   localparam int SW  = eatq_pkg::SC_W;
   localparam int PW  = eatq_pkg::PROD_W;
   localparam int CW  = PW + 1;
   localparam int WF  = eatq_pkg::WORK_FRAC;
   localparam int SH  = 2 * WF - QUAT_FRAC_BITS;
   localparam logic signed [PW-1:0] HALF_W = PW'(1) <<< (WF - 1);
   localparam logic signed [CW-1:0] HALF_Q = CW'(1) <<< (SH - 1);
   localparam logic signed [CW-1:0] LIM_Q  = CW'(1) <<< QUAT_FRAC_BITS;
   localparam logic signed [QW-1:0] Q_ONE  = QW'(1) <<< QUAT_FRAC_BITS;
   localparam logic [3:0]           ADD_MASK = 4'b1010;

   logic                 adv;
   logic [LAT-1:0]       vld_ff;
   logic [LAT-1:0]       vld_in;
   logic signed [SW-1:0] sr, cr, sp, cp, sy, cy;
   logic signed [PW-1:0] pp_ff [0:3];
   logic signed [PW-1:0] pp_in [0:3];
   logic signed [SW-1:0] ys_a_ff, yc_a_ff, ys_b_ff, yc_b_ff;
   logic signed [SW-1:0] pr_ff [0:3];
   logic signed [SW-1:0] pr_in [0:3];
   logic signed [PW-1:0] mc_ff [0:7];
   logic signed [PW-1:0] mc_in [0:7];
   logic signed [CW-1:0] acc   [0:3];
   logic signed [CW-1:0] rnd   [0:3];
   logic signed [QW-1:0] q_ff  [0:3];
   logic signed [QW-1:0] q_in  [0:3];

   assign adv            = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign vld_in         = {vld_ff[LAT-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   eatq_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(N)) u_roll (
      .clock(clock), .enable(adv), .angle(req_chan.roll_angle), .sin_val(sr), .cos_val(cr)
   );
   eatq_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(N)) u_pitch (
      .clock(clock), .enable(adv), .angle(req_chan.pitch_angle), .sin_val(sp), .cos_val(cp)
   );
   eatq_cordic #(.ANGLE_BITS(ANGLE_BITS), .STEPS(N)) u_yaw (
      .clock(clock), .enable(adv), .angle(req_chan.yaw_angle), .sin_val(sy), .cos_val(cy)
   );

   assign pp_in[0] = PW'(sr) * PW'(cp);
   assign pp_in[1] = PW'(cr) * PW'(cp);
   assign pp_in[2] = PW'(cr) * PW'(sp);
   assign pp_in[3] = PW'(sr) * PW'(sp);

   for (genvar k = 0; k < 4; k++) begin : g_pair
      logic signed [PW-1:0] pr_full;
      assign pr_full  = (pp_ff[k] + HALF_W) >>> WF;
      assign pr_in[k] = SW'(pr_full);
   end

   assign mc_in[0] = PW'(pr_ff[0]) * PW'(yc_b_ff);
   assign mc_in[1] = PW'(pr_ff[2]) * PW'(ys_b_ff);
   assign mc_in[2] = PW'(pr_ff[2]) * PW'(yc_b_ff);
   assign mc_in[3] = PW'(pr_ff[0]) * PW'(ys_b_ff);
   assign mc_in[4] = PW'(pr_ff[1]) * PW'(ys_b_ff);
   assign mc_in[5] = PW'(pr_ff[3]) * PW'(yc_b_ff);
   assign mc_in[6] = PW'(pr_ff[1]) * PW'(yc_b_ff);
   assign mc_in[7] = PW'(pr_ff[3]) * PW'(ys_b_ff);

   for (genvar k = 0; k < 4; k++) begin : g_comp
      assign acc[k]  = ADD_MASK[k] ? CW'(mc_ff[2*k]) + CW'(mc_ff[2*k+1])
                                   : CW'(mc_ff[2*k]) - CW'(mc_ff[2*k+1]);
      assign rnd[k]  = (acc[k] + HALF_Q) >>> SH;
      assign q_in[k] = (rnd[k] > LIM_Q) ? QW'(LIM_Q) :
                       (rnd[k] < -LIM_Q) ? QW'(-LIM_Q) : QW'(rnd[k]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            pp_ff[k] <= pp_in[k];
            pr_ff[k] <= pr_in[k];
            q_ff[k]  <= q_in[k];
         end
         for (int k = 0; k < 8; k++) begin
            mc_ff[k] <= mc_in[k];
         end
         ys_a_ff <= sy;
         yc_a_ff <= cy;
         ys_b_ff <= ys_a_ff;
         yc_b_ff <= yc_a_ff;
      end
   end

   assign rsp_chan.valid  = vld_ff[LAT-1];
   assign rsp_chan.quat_x = q_ff[0];
   assign rsp_chan.quat_y = q_ff[1];
   assign rsp_chan.quat_z = q_ff[2];
   assign rsp_chan.quat_w = q_ff[3];

   // An accepted word always enters the first stage.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> vld_ff[0])
      else $error("accepted word did not enter the pipeline");

   // A stalled pipeline keeps every valid bit in place.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("valid bits moved during a stall");

   // Input is refused while a finished word waits.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input accepted while the output stalls");

   // The delivered x and w components lie within plus or minus one.
   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (q_ff[0] <= Q_ONE && q_ff[0] >= -Q_ONE &&
                          q_ff[3] <= Q_ONE && q_ff[3] >= -Q_ONE))
      else $error("quaternion component out of range");

endmodule

FILE: tb/quat_result_monitor.sv
// Result monitor for the Euler angle to quaternion converter: predicts each
// quaternion from the accepted angle words and compares it with the output.
// Depends on eatq_pkg and the eatq_req_if and eatq_rsp_if channel interfaces.
module quat_result_monitor #(
   parameter int ANGLE_BITS     = eatq_pkg::ANGLE_BITS_DEF,
   parameter int QUAT_FRAC_BITS = eatq_pkg::QUAT_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS   = eatq_pkg::CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   eatq_req_if  req_tap,
   eatq_rsp_if  rsp_tap,
   output int   fault_count,
   output int   pending_count,
   output int   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QW        = QUAT_FRAC_BITS + 2;
   localparam int FRAC      = eatq_pkg::WORK_FRAC;
   localparam int STEP_LIM  = eatq_pkg::TABLE_LEN;
   localparam int MAX_SHOWN = 10;

   localparam longint ARCTAN_TURN32 [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0
   };

   typedef struct packed {
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
      logic signed [QW-1:0] w;
   } quat_type;

   quat_type expected_quats[$];

   function automatic longint round_shift(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint saturate(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Sine and cosine of half the binary angle, Q20.
   function automatic void half_sin_cos(input logic signed [ANGLE_BITS-1:0] ang,
                                        output longint s, output longint c);
      longint z;
      longint x;
      longint y;
      longint dx;
      longint dy;
      int     n;
      int     i;
      z = longint'(ang) * (longint'(1) <<< (33 - ANGLE_BITS));
      x = longint'(eatq_pkg::CORDIC_GAIN);
      y = longint'(0);
      n = (CORDIC_STEPS > STEP_LIM) ? STEP_LIM : CORDIC_STEPS;
      for (i = 0; i < n; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_TURN32[i] * 4;
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_TURN32[i] * 4;
         end
      end
      c = saturate(round_shift(x, eatq_pkg::VEC_FRAC - FRAC), longint'(1) <<< FRAC);
      s = saturate(round_shift(y, eatq_pkg::VEC_FRAC - FRAC), longint'(1) <<< FRAC);
   endfunction

   function automatic logic signed [QW-1:0] blend_pair(input longint p, input longint q,
                                                       input longint r, input longint t,
                                                       input bit add);
      longint               acc;
      logic signed [QW-1:0] res;
      acc = add ? p * q + r * t : p * q - r * t;
      acc = saturate(round_shift(acc, 2 * FRAC - QUAT_FRAC_BITS),
                     longint'(1) <<< QUAT_FRAC_BITS);
      res = acc[QW-1:0];
      return res;
   endfunction

   function automatic quat_type euler_to_quat(input logic signed [ANGLE_BITS-1:0] roll,
                                              input logic signed [ANGLE_BITS-1:0] pitch,
                                              input logic signed [ANGLE_BITS-1:0] yaw);
      longint   sr, cr, sp, cp, sy, cy;
      longint   sr_cp, cr_cp, cr_sp, sr_sp;
      quat_type q;
      half_sin_cos(roll, sr, cr);
      half_sin_cos(pitch, sp, cp);
      half_sin_cos(yaw, sy, cy);
      sr_cp = round_shift(sr * cp, FRAC);
      cr_cp = round_shift(cr * cp, FRAC);
      cr_sp = round_shift(cr * sp, FRAC);
      sr_sp = round_shift(sr * sp, FRAC);
      q.x = blend_pair(sr_cp, cy, cr_sp, sy, 1'b0);
      q.y = blend_pair(cr_sp, cy, sr_cp, sy, 1'b1);
      q.z = blend_pair(cr_cp, sy, sr_sp, cy, 1'b0);
      q.w = blend_pair(cr_cp, cy, sr_sp, sy, 1'b1);
      return q;
   endfunction

   initial begin
      fault_count   = 0;
      pending_count = 0;
      checked_count = 0;
   end

   always @(posedge clock) begin
      quat_type want;
      if (!reset) begin
         if (rsp_tap.valid && rsp_tap.ready) begin
            if (expected_quats.size() == 0) begin
               fault_count = fault_count + 1;
               if (fault_count <= MAX_SHOWN)
                  $display("%0t: quaternion word with no pending input: x=%0d y=%0d z=%0d w=%0d",
                           $realtime, rsp_tap.quat_x, rsp_tap.quat_y, rsp_tap.quat_z,
                           rsp_tap.quat_w);
            end else begin
               want = expected_quats.pop_front();
               checked_count = checked_count + 1;
               if (rsp_tap.quat_x !== want.x || rsp_tap.quat_y !== want.y ||
                   rsp_tap.quat_z !== want.z || rsp_tap.quat_w !== want.w) begin
                  fault_count = fault_count + 1;
                  // Components are listed in the order x, y, z, w.
                  if (fault_count <= MAX_SHOWN)
                     $display("%0t: mismatch, expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              $realtime, want.x, want.y, want.z, want.w, rsp_tap.quat_x,
                              rsp_tap.quat_y, rsp_tap.quat_z, rsp_tap.quat_w);
               end
            end
         end
         if (req_tap.valid && req_tap.ready)
            expected_quats.push_back(euler_to_quat(req_tap.roll_angle, req_tap.pitch_angle,
                                                   req_tap.yaw_angle));
         pending_count = expected_quats.size();
      end
   end

endmodule

FILE: tb/tb_euler_angles_to_quaternion.sv
// Top of the Euler angle to quaternion testbench: clock, reset, angle stimulus
// with bursts, output stalls and the verdict. Depends on eatq_pkg, the channel
// interfaces, euler_angles_to_quaternion and quat_result_monitor.
module tb_euler_angles_to_quaternion;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AW          = eatq_pkg::ANGLE_BITS_DEF;
   localparam int RANDOM_WORDS = 700;
   localparam int DRAIN_CYCLES = eatq_pkg::CORDIC_STEPS_DEF + 40;

   typedef enum int { STALL_NONE, STALL_COIN, STALL_PERIODIC } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fault_count;
   int pending_count;
   int checked_count;
   int sent_count     = 0;
   int directed_count = 0;
   int burst_left     = 0;

   stall_mode_type stall_mode  = STALL_NONE;
   int             stall_left  = 0;
   int             stall_period = 1;
   int             stall_low   = 0;
   int             stall_phase = 0;

   eatq_req_if req_chan ();
   eatq_rsp_if rsp_chan ();

   euler_angles_to_quaternion dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   quat_result_monitor quat_mon (
      .clock         (clock),
      .reset         (reset),
      .req_tap       (req_chan),
      .rsp_tap       (rsp_chan),
      .fault_count   (fault_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // The receiver switches between always ready, coin-flip and periodic stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode   = stall_mode_type'($urandom_range(0, 2));
            stall_left   = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 16);
            stall_low    = $urandom_range(1, stall_period - 1);
            stall_phase  = 0;
         end
         stall_left  = stall_left - 1;
         stall_phase = (stall_phase + 1) % stall_period;
         case (stall_mode)
            STALL_NONE:     rsp_chan.ready <= 1'b1;
            STALL_COIN:     rsp_chan.ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: rsp_chan.ready <= (stall_phase >= stall_low);
            default:        rsp_chan.ready <= 1'b1;
         endcase
      end
   end

   function automatic int pick_angle(input int mode);
      int a;
      case (mode)
         5: begin
            case ($urandom_range(0, 8))
               0:       a = -32768;
               1:       a = -32767;
               2:       a = -1;
               3:       a = 0;
               4:       a = 1;
               5:       a = 32766;
               6:       a = 32767;
               7:       a = 16384;
               default: a = -16384;
            endcase
         end
         6: a = int'($urandom_range(0, 128)) - 64;
         7: a = ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 63))
                                             : -32768 + int'($urandom_range(0, 63));
         default: a = int'($urandom());
      endcase
      return a;
   endfunction

   task automatic send_angles(input int roll, input int pitch, input int yaw);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 9);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.roll_angle  <= AW'(roll);
      req_chan.pitch_angle <= AW'(pitch);
      req_chan.yaw_angle   <= AW'(yaw);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count = sent_count + 1;
   endtask

   initial begin
      int mode;
      req_chan.valid       = 1'b0;
      req_chan.roll_angle  = '0;
      req_chan.pitch_angle = '0;
      req_chan.yaw_angle   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Identity and near-identity words push w to full scale, where rounding
      // overshoot must saturate. The most negative angle stands for -pi.
      send_angles(0, 0, 0);
      send_angles(1, -1, 1);
      send_angles(-32768, 0, 0);
      send_angles(0, -32768, 0);
      send_angles(0, 0, -32768);
      send_angles(32767, 0, 0);
      send_angles(0, 32767, 0);
      send_angles(0, 0, 32767);
      send_angles(16384, 0, 0);
      send_angles(0, -16384, 0);
      send_angles(0, 0, 16384);
      send_angles(-32768, -32768, -32768);
      send_angles(32767, 32767, 32767);
      send_angles(32767, -32768, 0);
      send_angles(-32768, 32767, -1);
      send_angles(16384, 16384, 16384);
      send_angles(-16384, -16384, -16384);
      send_angles(16384, -16384, 32767);
      send_angles(-1, -1, -1);
      send_angles(-32767, 32766, -32768);
      directed_count = sent_count;

      repeat (RANDOM_WORDS) begin
         mode = $urandom_range(0, 9);
         send_angles(pick_angle(mode), pick_angle(mode), pick_angle(mode));
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d angle words (%0d directed edge cases, the rest random in bursts).",
               sent_count, directed_count);
      $display("Checked %0d quaternion words under output stalls, %0d faults.",
               checked_count, fault_count);
      if (fault_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
